FILE: sv/esa_pkg.sv
// esa_pkg: shared constants and types for the encoder setpoint adjuster
// used by the controller, the datapath and the top level
`default_nettype none
package esa_pkg;

	// configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegStepSpeed   = 3'd0;
	localparam logic [CfgIdxW-1:0] RegStepRpm     = 3'd1;
	localparam logic [CfgIdxW-1:0] RegMaxSpeed    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegMaxRpm      = 3'd3;
	localparam logic [CfgIdxW-1:0] RegEncHoldoff  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegBtnHoldoff  = 3'd5;
	localparam logic [CfgIdxW-1:0] RegTimerClock  = 3'd6;

	// register reset values
	localparam logic [7:0]  StepSpeedRst  = 8'd5;
	localparam logic [11:0] StepRpmRst    = 12'd100;
	localparam logic [9:0]  MaxSpeedRst   = 10'd300;
	localparam logic [15:0] MaxRpmRst     = 16'd16000;
	localparam logic [23:0] EncHoldoffRst = 24'd1000;
	localparam logic [15:0] BtnHoldoffRst = 16'd50;
	localparam logic [31:0] TimerClockRst = 32'd40000000;

	// event kinds
	localparam logic CmdEncoder = 1'b0;
	localparam logic CmdButton  = 1'b1;

	// step codes
	localparam logic signed [1:0] StepNone = 2'sb00;
	localparam logic signed [1:0] StepUp   = 2'sb01;
	localparam logic signed [1:0] StepDown = 2'sb11;

	// reload divider
	localparam int DivSteps = 32;
	localparam int DivCntW  = $clog2(DivSteps);

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic check;
		logic apply;
		logic div_start;
		logic div_step;
		logic load_out;
	} esa_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_last;
	} esa_stat_t;

endpackage
`default_nettype wire

FILE: sv/esa_in_if.sv
// esa_in_if: event channel (encoder sample or button press)
// valid/ready handshake, no dependencies
`default_nettype none
interface esa_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        pin_a;
	logic        pin_b;
	logic [47:0] now_us;
	logic [31:0] now_ticks;

	modport source (output valid, cmd, pin_a, pin_b, now_us, now_ticks, input ready);
	modport sink (input valid, cmd, pin_a, pin_b, now_us, now_ticks, output ready);
endinterface
`default_nettype wire

FILE: sv/esa_out_if.sv
// esa_out_if: result channel, setpoints and engine timer reload
// valid/ready handshake, no dependencies
`default_nettype none
interface esa_out_if;
	logic              valid;
	logic              ready;
	logic              accepted;
	logic signed [1:0] step;
	logic              selected;
	logic [9:0]        vehicle_speed;
	logic [15:0]       engine_speed;
	logic [30:0]       rpm_reload;
	logic              rpm_running;

	modport source (output valid, accepted, step, selected, vehicle_speed, engine_speed,
		rpm_reload, rpm_running, input ready);
	modport sink (input valid, accepted, step, selected, vehicle_speed, engine_speed,
		rpm_reload, rpm_running, output ready);
endinterface
`default_nettype wire

FILE: sv/esa_ctrl.sv
// esa_ctrl: sequencing state machine and output beat valid
// depends on esa_pkg for command and status types
`default_nettype none
module esa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                evt_valid,
	output logic                     evt_ready,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output esa_pkg::esa_cmd_t        cmd,
	input  wire esa_pkg::esa_stat_t  stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_APPLY = 6'b000100,
		S_LOAD  = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign evt_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (evt_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/esa_dp.sv
// esa_dp: configuration registers, event state, setpoint update, reload divider
// and output beat register; depends on esa_pkg and esa_in_if/esa_out_if
`default_nettype none
module esa_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [esa_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [esa_pkg::CfgDataW-1:0]    cfg_data,
	input  wire esa_pkg::esa_cmd_t               cmd,
	output esa_pkg::esa_stat_t                   stat,
	esa_in_if.sink                               evt,
	esa_out_if.source                            res
);

	// configuration registers
	logic [7:0]  step_speed_q;
	logic [11:0] step_rpm_q;
	logic [9:0]  max_speed_q;
	logic [15:0] max_rpm_q;
	logic [23:0] enc_holdoff_q;
	logic [15:0] btn_holdoff_q;
	logic [31:0] timer_clock_q;

	// event state
	logic        prev_a_q, prev_b_q;
	logic [47:0] enc_stamp_q;
	logic [31:0] btn_stamp_q;
	logic        select_rpm_q;
	logic [9:0]  speed_q;
	logic [15:0] rpm_q;

	// latched event
	logic        ev_cmd_q, ev_a_q, ev_b_q;
	logic [47:0] ev_us_q;
	logic [31:0] ev_ticks_q;

	// check results
	logic              acc_q;
	logic signed [1:0] step_q;

	// divider
	logic [16:0]                  div_rem_q;
	logic [31:0]                  div_dq_q;
	logic [16:0]                  divisor_q;
	logic [esa_pkg::DivCntW-1:0]  div_cnt_q;

	// output beat register
	logic              out_acc_q;
	logic signed [1:0] out_step_q;
	logic              out_sel_q;
	logic [9:0]        out_speed_q;
	logic [15:0]       out_rpm_q;
	logic [30:0]       out_reload_q;
	logic              out_run_q;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_speed_q  <= esa_pkg::StepSpeedRst;
			step_rpm_q    <= esa_pkg::StepRpmRst;
			max_speed_q   <= esa_pkg::MaxSpeedRst;
			max_rpm_q     <= esa_pkg::MaxRpmRst;
			enc_holdoff_q <= esa_pkg::EncHoldoffRst;
			btn_holdoff_q <= esa_pkg::BtnHoldoffRst;
			timer_clock_q <= esa_pkg::TimerClockRst;
		end else if (cfg_we) begin
			case (cfg_index)
				esa_pkg::RegStepSpeed:  step_speed_q  <= cfg_data[7:0];
				esa_pkg::RegStepRpm:    step_rpm_q    <= cfg_data[11:0];
				esa_pkg::RegMaxSpeed:   max_speed_q   <= cfg_data[9:0];
				esa_pkg::RegMaxRpm:     max_rpm_q     <= cfg_data[15:0];
				esa_pkg::RegEncHoldoff: enc_holdoff_q <= cfg_data[23:0];
				esa_pkg::RegBtnHoldoff: btn_holdoff_q <= cfg_data[15:0];
				esa_pkg::RegTimerClock: timer_clock_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latch the accepted event beat
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ev_cmd_q   <= evt.cmd;
			ev_a_q     <= evt.pin_a;
			ev_b_q     <= evt.pin_b;
			ev_us_q    <= evt.now_us;
			ev_ticks_q <= evt.now_ticks;
		end
	end

	// hold-off check and quadrature decode
	logic [48:0]       us_diff;
	logic [31:0]       tick_diff;
	logic              enc_ok, btn_ok;
	logic signed [1:0] dec_step;

	assign us_diff   = {1'b0, ev_us_q} - {1'b0, enc_stamp_q};
	assign tick_diff = ev_ticks_q - btn_stamp_q;
	assign enc_ok    = !us_diff[48] && (us_diff[47:0] > {24'd0, enc_holdoff_q});
	assign btn_ok    = tick_diff > {16'd0, btn_holdoff_q};

	// edges on a take priority over edges on b
	always_comb begin
		if (prev_a_q && !ev_a_q)
			dec_step = ev_b_q ? esa_pkg::StepUp : esa_pkg::StepDown;
		else if (!prev_a_q && ev_a_q)
			dec_step = ev_b_q ? esa_pkg::StepDown : esa_pkg::StepUp;
		else if (prev_b_q && !ev_b_q)
			dec_step = ev_a_q ? esa_pkg::StepDown : esa_pkg::StepUp;
		else if (!prev_b_q && ev_b_q)
			dec_step = ev_a_q ? esa_pkg::StepUp : esa_pkg::StepDown;
		else
			dec_step = esa_pkg::StepNone;
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			if (ev_cmd_q == esa_pkg::CmdEncoder) begin
				acc_q  <= enc_ok;
				step_q <= enc_ok ? dec_step : esa_pkg::StepNone;
			end else begin
				acc_q  <= btn_ok;
				step_q <= esa_pkg::StepNone;
			end
		end
	end

	// move the selected setpoint and clamp to 0..max
	logic [15:0]        cur_sp, max_sp;
	logic [11:0]        inc_sp;
	logic signed [17:0] moved;
	logic [15:0]        clamped;

	always_comb begin
		cur_sp = select_rpm_q ? rpm_q : {6'd0, speed_q};
		max_sp = select_rpm_q ? max_rpm_q : {6'd0, max_speed_q};
		inc_sp = select_rpm_q ? step_rpm_q : {4'd0, step_speed_q};
		case (step_q)
			esa_pkg::StepUp:   moved = $signed({2'b00, cur_sp}) + $signed({6'd0, inc_sp});
			esa_pkg::StepDown: moved = $signed({2'b00, cur_sp}) - $signed({6'd0, inc_sp});
			default:           moved = $signed({2'b00, cur_sp});
		endcase
		if (moved < 0)
			clamped = '0;
		else if (moved > $signed({2'b00, max_sp}))
			clamped = max_sp;
		else
			clamped = moved[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q     <= 1'b0;
			prev_b_q     <= 1'b0;
			enc_stamp_q  <= '0;
			btn_stamp_q  <= '0;
			select_rpm_q <= 1'b1;
			speed_q      <= '0;
			rpm_q        <= '0;
		end else if (cmd.apply && acc_q) begin
			if (ev_cmd_q == esa_pkg::CmdEncoder) begin
				prev_a_q    <= ev_a_q;
				prev_b_q    <= ev_b_q;
				enc_stamp_q <= ev_us_q;
				if (select_rpm_q) rpm_q <= clamped;
				else speed_q <= clamped[9:0];
			end else begin
				select_rpm_q <= !select_rpm_q;
				btn_stamp_q  <= ev_ticks_q;
			end
		end
	end

	// restoring divider: timer clock over twice the rpm, one bit a cycle
	logic [17:0] rem_sh;
	logic        rem_ge;
	logic [17:0] rem_sub;

	assign rem_sh  = {div_rem_q, div_dq_q[31]};
	assign rem_ge  = rem_sh >= {1'b0, divisor_q};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign stat.div_last = (div_cnt_q == esa_pkg::DivCntW'(esa_pkg::DivSteps - 1));

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			div_dq_q  <= timer_clock_q;
			divisor_q <= {rpm_q, 1'b0};
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_rem_q <= rem_ge ? rem_sub[16:0] : rem_sh[16:0];
			div_dq_q  <= {div_dq_q[30:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// reload is quotient minus one, saturating at zero, and zero when stopped
	logic        running;
	logic [30:0] reload;

	assign running = (rpm_q != '0);
	always_comb begin
		if (!running || div_dq_q == '0) reload = '0;
		else reload = div_dq_q[30:0] - 31'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_acc_q    <= acc_q;
			out_step_q   <= step_q;
			out_sel_q    <= select_rpm_q;
			out_speed_q  <= speed_q;
			out_rpm_q    <= rpm_q;
			out_reload_q <= reload;
			out_run_q    <= running;
		end
	end

	assign res.accepted      = out_acc_q;
	assign res.step          = out_step_q;
	assign res.selected      = out_sel_q;
	assign res.vehicle_speed = out_speed_q;
	assign res.engine_speed  = out_rpm_q;
	assign res.rpm_reload    = out_reload_q;
	assign res.rpm_running   = out_run_q;

endmodule
`default_nettype wire

FILE: sv/encoder_setpoint_adjuster_unit.sv
// encoder_setpoint_adjuster_unit: top level, controller plus datapath
// depends on esa_pkg, esa_in_if, esa_out_if, esa_ctrl, esa_dp
//
//   port   direction  beat contents
//   evt    in         cmd, pin_a, pin_b, now_us, now_ticks
//   res    out        accepted, step, selected, speeds, rpm_reload, rpm_running
//   cfg    in         cfg_we, cfg_index, cfg_data (write only)
//
// an event beat goes from acceptance to its result beat through check, apply,
// divider load and the bit-serial reload divider, then the output load.
// one event is in work at a time; the next is taken once the result is registered.
// a stalled result holds in the output register; only a second result waits on it.
// reset restores register defaults and clears setpoints and time stamps at once.
`default_nettype none
module encoder_setpoint_adjuster_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	esa_in_if.sink                             evt,
	esa_out_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [esa_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [esa_pkg::CfgDataW-1:0]  cfg_data
);

	esa_pkg::esa_cmd_t  cmd;
	esa_pkg::esa_stat_t stat;

	esa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	esa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.evt       (evt),
		.res       (res)
	);

endmodule
`default_nettype wire

FILE: test/tb_encoder_setpoint_adjuster_unit.sv
// tb_encoder_setpoint_adjuster_unit: self-checking bench for the encoder setpoint adjuster
// depends on esa_pkg, esa_in_if, esa_out_if and encoder_setpoint_adjuster_unit
// an in-bench model predicts every result beat; directed cases, random traffic, then a timestamp case
`default_nettype none
module tb_encoder_setpoint_adjuster_unit;
	import esa_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int MaxReports = 10;
	// index past the last register, writes to it must be dropped
	localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

	// one result beat as the block reports it
	typedef struct packed {
		logic              accepted;
		logic signed [1:0] step;
		logic              selected;
		logic [9:0]        vehicle_speed;
		logic [15:0]       engine_speed;
		logic [30:0]       rpm_reload;
		logic              rpm_running;
	} setpoint_report_t;

	// register set
	typedef struct {
		logic [7:0]  step_speed;
		logic [11:0] step_rpm;
		logic [9:0]  max_speed;
		logic [15:0] max_rpm;
		logic [23:0] enc_holdoff;
		logic [15:0] btn_holdoff;
		logic [31:0] timer_clock;
	} setup_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	esa_in_if  evt_bus ();
	esa_out_if res_bus ();

	encoder_setpoint_adjuster_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_bus),
		.res       (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// adjuster state as the bench sees it
	setup_t cfg = '{StepSpeedRst, StepRpmRst, MaxSpeedRst, MaxRpmRst,
		EncHoldoffRst, BtnHoldoffRst, TimerClockRst};
	logic        prev_a    = 1'b0;
	logic        prev_b    = 1'b0;
	logic [47:0] enc_stamp = '0;
	logic [31:0] btn_stamp = '0;
	logic        sel_rpm   = 1'b1;
	logic [9:0]  speed_sp  = '0;
	logic [15:0] rpm_sp    = '0;

	setpoint_report_t pending_reports[$];

	logic steady  = 1'b0;
	logic wind_up = 1'b1;
	int   errors    = 0;
	int   n_events  = 0;
	int   n_steps   = 0;
	int   n_rejects = 0;
	int   n_toggles = 0;
	int   n_clamps  = 0;
	int   n_setups  = 0;
	int   cycle_count = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// run limit
	initial begin : watchdog
		wait (cycle_count >= CycleLimit);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_reports.size());
		$display("FAILURE");
		$finish;
	end

	// idle length for either side: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// apply one event to the bench state and return the beat it should produce
	function automatic setpoint_report_t apply_event(input logic c, input logic a,
			input logic b, input logic [47:0] us, input logic [31:0] tk);
		setpoint_report_t r;
		logic [31:0] tick_gap;
		logic [63:0] quot;
		longint cur, inc, lim, moved;
		int dir;
		r = '0;
		if (c == CmdEncoder) begin
			if (us >= enc_stamp && us - enc_stamp > 48'(cfg.enc_holdoff)) begin
				r.accepted = 1'b1;
				// edges on a win over edges on b
				if (prev_a && !a)
					r.step = b ? StepUp : StepDown;
				else if (!prev_a && a)
					r.step = b ? StepDown : StepUp;
				else if (prev_b && !b)
					r.step = a ? StepDown : StepUp;
				else if (!prev_b && b)
					r.step = a ? StepUp : StepDown;
				else
					r.step = StepNone;
				enc_stamp = us;
				prev_a = a;
				prev_b = b;
				dir = (r.step == StepUp) ? 1 : (r.step == StepDown) ? -1 : 0;
				cur = sel_rpm ? longint'(rpm_sp) : longint'(speed_sp);
				inc = sel_rpm ? longint'(cfg.step_rpm) : longint'(cfg.step_speed);
				lim = sel_rpm ? longint'(cfg.max_rpm) : longint'(cfg.max_speed);
				// clamp even with no step so a lowered max bites
				moved = cur + inc * dir;
				if (moved > lim) begin
					moved = lim;
					n_clamps++;
				end
				if (moved < 0) begin
					moved = 0;
					n_clamps++;
				end
				if (sel_rpm)
					rpm_sp = moved[15:0];
				else
					speed_sp = moved[9:0];
				if (dir != 0)
					n_steps++;
			end else begin
				n_rejects++;
			end
		end else begin
			// tick difference wraps
			tick_gap = tk - btn_stamp;
			if (tick_gap > 32'(cfg.btn_holdoff)) begin
				r.accepted = 1'b1;
				sel_rpm = ~sel_rpm;
				btn_stamp = tk;
				n_toggles++;
			end else begin
				n_rejects++;
			end
		end
		r.selected = sel_rpm;
		r.vehicle_speed = speed_sp;
		r.engine_speed = rpm_sp;
		r.rpm_running = (rpm_sp != 0);
		// reload saturates at zero when the clock is under twice the rpm
		if (rpm_sp != 0) begin
			quot = 64'(cfg.timer_clock) / (64'(rpm_sp) * 64'd2);
			r.rpm_reload = (quot != 0) ? 31'(quot - 1) : '0;
		end
		return r;
	endfunction

	function automatic string report_text(input setpoint_report_t r);
		return $sformatf("acc=%0d step=%0d sel=%0d speed=%0d rpm=%0d reload=%0d run=%0d",
			r.accepted, r.step, r.selected, r.vehicle_speed, r.engine_speed,
			r.rpm_reload, r.rpm_running);
	endfunction

	// next encoder levels one quadrature step on, from the stored levels
	function automatic logic [1:0] turn(input logic up);
		return up ? {~prev_b, prev_a} : {prev_b, ~prev_a};
	endfunction

	// stamps just past the hold-off
	function automatic logic [47:0] fresh_us();
		return enc_stamp + 48'(cfg.enc_holdoff) + 48'd1 + 48'($urandom_range(0, 300));
	endfunction

	function automatic logic [31:0] fresh_tick();
		return btn_stamp + 32'(cfg.btn_holdoff) + 32'd1 + $urandom_range(0, 300);
	endfunction

	// zero, top, or something usual
	function automatic logic [31:0] pick_value(input logic [31:0] top, input logic [31:0] usual);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return top;
		return $urandom_range(0, usual);
	endfunction

	function automatic setup_t random_setup();
		setup_t s;
		int unsigned r;
		s.step_speed  = 8'(pick_value(255, 30));
		s.step_rpm    = 12'(pick_value(4095, 800));
		s.max_speed   = 10'(pick_value(1023, 1023));
		s.max_rpm     = 16'(pick_value(65535, 65535));
		s.enc_holdoff = 24'(pick_value(24'hFFFFFF, 3000));
		s.btn_holdoff = 16'(pick_value(16'hFFFF, 200));
		r = $urandom_range(0, 99);
		if (r < 10)
			s.timer_clock = 32'd1;
		else if (r < 20)
			s.timer_clock = 32'hFFFF_FFFF;
		else
			s.timer_clock = $urandom_range(1000, 100000000);
		return s;
	endfunction

	// result side: random back-pressure
	initial begin : result_backpressure
		int unsigned open_len, shut_len;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_bus.ready <= 1'b1;
			open_len = $urandom_range(1, 24);
			repeat (open_len) @(posedge clk);
			shut_len = pick_gap();
			if (shut_len != 0) begin
				res_bus.ready <= 1'b0;
				repeat (shut_len) @(posedge clk);
			end
		end
	end

	task automatic note_fault(input string what, input setpoint_report_t want,
			input setpoint_report_t got);
		errors++;
		if (errors <= MaxReports) begin
			$display("[%0t] %s", $realtime, what);
			$display("    want %s", report_text(want));
			$display("    got  %s", report_text(got));
		end
	endtask

	// result beat check against the oldest prediction
	always @(posedge clk) begin : result_check
		setpoint_report_t got, want;
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got.accepted      = res_bus.accepted;
			got.step          = res_bus.step;
			got.selected      = res_bus.selected;
			got.vehicle_speed = res_bus.vehicle_speed;
			got.engine_speed  = res_bus.engine_speed;
			got.rpm_reload    = res_bus.rpm_reload;
			got.rpm_running   = res_bus.rpm_running;
			if (pending_reports.size() == 0) begin
				note_fault("result beat with nothing outstanding", '0, got);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want)
					note_fault("result beat mismatch", want, got);
			end
		end
	end

	// one event beat, predicted once the block takes it
	task automatic send_event(input logic c, input logic a, input logic b,
			input logic [47:0] us, input logic [31:0] tk);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			evt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_bus.valid     <= 1'b1;
		evt_bus.cmd       <= c;
		evt_bus.pin_a     <= a;
		evt_bus.pin_b     <= b;
		evt_bus.now_us    <= us;
		evt_bus.now_ticks <= tk;
		do @(posedge clk); while (evt_bus.ready !== 1'b1);
		pending_reports.push_back(apply_event(c, a, b, us, tk));
		n_events++;
	endtask

	// unused fields carry noise
	task automatic send_encoder(input logic [1:0] pins, input logic [47:0] us);
		send_event(CmdEncoder, pins[1], pins[0], us, $urandom);
	endtask

	task automatic send_button(input logic [31:0] tk);
		send_event(CmdButton, 1'($urandom), 1'($urandom), 48'({$urandom, $urandom}), tk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		evt_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic cfg_poke(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// block must be idle here
	task automatic apply_setup(input setup_t s);
		cfg_poke(RegStepSpeed, 32'(s.step_speed));
		cfg_poke(RegStepRpm, 32'(s.step_rpm));
		cfg_poke(RegMaxSpeed, 32'(s.max_speed));
		cfg_poke(RegMaxRpm, 32'(s.max_rpm));
		cfg_poke(RegEncHoldoff, 32'(s.enc_holdoff));
		cfg_poke(RegBtnHoldoff, 32'(s.btn_holdoff));
		cfg_poke(RegTimerClock, s.timer_clock);
		cfg_poke(RegSpare, $urandom);
		cfg_we <= 1'b0;
		cfg = s;
		n_setups++;
	endtask

	// reset values: stamps at zero, hold-off edges on both kinds
	task automatic check_reset_defaults();
		send_encoder(2'b00, 48'd0);
		send_encoder(2'b00, 48'(EncHoldoffRst));
		send_encoder(2'b00, 48'(EncHoldoffRst) + 48'd1);
		send_button(32'(BtnHoldoffRst));
		send_button(32'(BtnHoldoffRst) + 32'd1);
	endtask

	// every edge of a and b both ways, no edge, both pins at once
	task automatic check_quadrature_decode();
		logic [1:0] walk [11] = '{2'b10, 2'b11, 2'b01, 2'b00, 2'b01, 2'b11,
			2'b10, 2'b00, 2'b00, 2'b11, 2'b00};
		foreach (walk[i])
			send_encoder(walk[i], fresh_us());
		// too soon, then going backwards
		send_encoder(2'b10, enc_stamp + 48'(cfg.enc_holdoff));
		send_encoder(2'b10, enc_stamp - 48'd1);
	endtask

	// exact hold-off, tick wrap
	task automatic check_button_toggle();
		send_button(btn_stamp + 32'(cfg.btn_holdoff));
		send_button(32'hFFFF_FFC0);
		send_button(32'h0000_0010);
		send_button(fresh_tick());
	endtask

	// registers at their limits, lowered max, saturated reload
	task automatic check_register_extremes();
		settle();
		apply_setup('{8'hFF, 12'hFFF, 10'h3FF, 16'hFFFF, 24'd0, 16'd0, 32'hFFFF_FFFF});
		send_encoder(turn(1'b1), enc_stamp + 48'd1);
		send_encoder(turn(1'b1), enc_stamp + 48'd1);
		send_encoder(turn(1'b1), enc_stamp);
		send_button(btn_stamp);
		send_button(btn_stamp + 32'd1);
		settle();
		apply_setup('{8'd0, 12'd0, 10'd0, 16'd150, 24'hFFFFFF, 16'hFFFF, 32'd1});
		send_encoder({prev_a, prev_b}, enc_stamp + 48'hFF_FFFF);
		send_encoder({prev_a, prev_b}, enc_stamp + 48'h100_0000);
		send_button(btn_stamp + 32'h1_0000);
		send_encoder(turn(1'b0), fresh_us());
	endtask

	task automatic random_item();
		int unsigned r, p, t;
		logic [1:0] pins;
		logic [47:0] us;
		logic [31:0] tk;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, 99);
		t = $urandom_range(0, 99);
		if (r < 78) begin
			if ($urandom_range(0, 99) < 5)
				wind_up = ~wind_up;
			// mostly clean quadrature, some bounce and noise
			if (p < 72)
				pins = turn(wind_up);
			else if (p < 86)
				pins = {prev_a, prev_b};
			else
				pins = 2'($urandom);
			if (t < 80)
				us = fresh_us();
			else if (t < 93)
				us = enc_stamp + 48'($urandom_range(0, cfg.enc_holdoff));
			else if (enc_stamp > 48'd1000)
				us = enc_stamp - 48'($urandom_range(1, 1000));
			else
				us = '0;
			send_encoder(pins, us);
		end else begin
			if (t < 75)
				tk = fresh_tick();
			else if (t < 92)
				tk = btn_stamp + $urandom_range(0, cfg.btn_holdoff);
			else
				tk = $urandom;
			send_button(tk);
		end
	endtask

	// phases of random traffic, each under a fresh register set
	task automatic run_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			apply_setup(random_setup());
			steady = (ph == 3);
			for (int i = 0; i < 150; i++) begin
				// sender holds off until everything is back
				if (i == 60 || $urandom_range(0, 199) == 0)
					settle();
				random_item();
			end
		end
		steady = 1'b0;
	endtask

	// stamps near the top of the 48-bit range
	task automatic check_timestamp_top();
		setup_t s;
		settle();
		s = random_setup();
		s.enc_holdoff = 24'd7;
		apply_setup(s);
		send_encoder(turn(1'b1), {1'b1, 47'($urandom)});
		send_encoder(turn(1'b1), 48'hFFFF_FFFF_FF00);
		repeat (4)
			send_encoder(2'($urandom), 48'({$urandom, $urandom}));
		send_encoder(turn(1'b0), 48'hFFFF_FFFF_FFFF);
		send_encoder(turn(1'b0), 48'd0);
	endtask

	// main sequence
	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		evt_bus.valid     <= 1'b0;
		evt_bus.cmd       <= CmdEncoder;
		evt_bus.pin_a     <= 1'b0;
		evt_bus.pin_b     <= 1'b0;
		evt_bus.now_us    <= '0;
		evt_bus.now_ticks <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_defaults();
		check_quadrature_decode();
		check_button_toggle();
		check_register_extremes();
		run_random_traffic();
		check_timestamp_top();

		// drain, then keep the clock running to catch stray results
		settle();
		repeat (60) @(posedge clk);

		$display("covered %0d events: %0d encoder steps, %0d toggles, %0d rejects, %0d clamps",
			n_events, n_steps, n_toggles, n_rejects, n_clamps);
		$display("over %0d register sets in %0d cycles, %0d faults", n_setups, cycle_count,
			errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/esa_pkg.sv
sv/esa_in_if.sv
sv/esa_out_if.sv
sv/esa_ctrl.sv
sv/esa_dp.sv
sv/encoder_setpoint_adjuster_unit.sv
test/tb_encoder_setpoint_adjuster_unit.sv
